// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define I2CM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants of the tick-driven I2C register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int HALF_W     = 16;
  localparam int ADDR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int REQ_W      = 2;
  localparam int BITCNT_W   = 4;
  localparam int BYTEIDX_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TICKS = 2'd1;

  // Reset values
  localparam logic [ADDR_W-1:0] DEV_ADDR_RST   = 7'h27;
  localparam logic [HALF_W-1:0] HALF_TICKS_RST = 16'd5;

  // Byte framing
  localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [BYTEIDX_W-1:0] IDX_ADDR      = 3'd0;
  localparam logic [BYTEIDX_W-1:0] IDX_REG       = 3'd1;
  localparam logic [BYTEIDX_W-1:0] IDX_RESTART   = 3'd2;
  localparam logic [BYTEIDX_W-1:0] IDX_LAST      = 3'd3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_RS_LOW,
    PH_RS_HIGH,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_NACK_LOW,
    PH_NACK_HIGH,
    PH_STOP_LOW,
    PH_STOP_HIGH,
    PH_STOP_REL
  } phase_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              nack_seen;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dev_addr;
    logic [HALF_W-1:0] half_ticks;
  } cfg_t;

endpackage

// File: hw/rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channels: request words, result words and register writes.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic                         valid;
  logic                         ready;
  logic [i2cm_pkg::REQ_W-1:0]   req_type;
  logic [i2cm_pkg::BYTE_W-1:0]  reg_addr;
  logic [i2cm_pkg::BYTE_W-1:0]  write_data;
  logic                         sda_in;

  modport source (output valid, req_type, reg_addr, write_data, sda_in, input ready);
  modport sink   (input valid, req_type, reg_addr, write_data, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         scl_level;
  logic                         sda_pull_low;
  logic                         busy_res;
  logic                         done_res;
  logic [i2cm_pkg::BYTE_W-1:0]  read_byte;
  logic                         nack_seen;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
                  nack_seen, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
                  nack_seen, output ready);
endinterface

interface i2cm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2cm_pkg::CFG_IDX_W-1:0]   idx;
  logic [i2cm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// File: hw/rtl/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// Device address and half period registers behind the write channel.
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  i2cm_cfg_if.sink        cfg_ch,
  output i2cm_pkg::cfg_t  cfg_o
);
  import i2cm_pkg::*;

  logic [ADDR_W-1:0] dev_addr_r, dev_addr_nxt;
  logic [HALF_W-1:0] half_r, half_nxt;

  assign cfg_ch.ready = 1'b1;

  // Decode the register index; drop writes beyond the list
  always_comb begin
    dev_addr_nxt = dev_addr_r;
    half_nxt     = half_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        CFG_DEV_ADDR:   dev_addr_nxt = cfg_ch.data[ADDR_W-1:0];
        CFG_HALF_TICKS: half_nxt     = cfg_ch.data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      half_r     <= HALF_TICKS_RST;
    end else begin
      dev_addr_r <= dev_addr_nxt;
      half_r     <= half_nxt;
    end
  end

  assign cfg_o.dev_addr   = dev_addr_r;
  assign cfg_o.half_ticks = half_r;

endmodule

// File: hw/rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus phase sequencer: one tick of I2C bus time per step.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cm_pkg::item_t  item,
  input  i2cm_pkg::cfg_t   cfg,
  output i2cm_pkg::res_t   res
);
  import i2cm_pkg::*;

  phase_t                 phase_r, phase_nxt, ph_e;
  logic [BITCNT_W-1:0]    bit_cnt_r, bit_cnt_nxt, bit_e, bit_inc;
  logic [BYTEIDX_W-1:0]   byte_idx_r, byte_idx_nxt, idx_e, idx_inc;
  logic [BYTE_W-1:0]      shift_r, shift_nxt, shift_e, rd_shift;
  logic [HALF_W-1:0]      tick_r, tick_nxt, tick_e, half_eff;
  logic                   is_read_r, is_read_nxt, is_read_e;
  logic [BYTE_W-1:0]      reg_r, reg_nxt, reg_e;
  logic [BYTE_W-1:0]      data_r, data_nxt, data_e;
  logic [BYTE_W-1:0]      last_read_r, last_read_nxt;
  logic                   nack_r, nack_nxt, nack_e;
  logic                   start, last;
  logic                   scl, pull, busy, done;

  // Byte sent at a given position of the transaction
  function automatic logic [BYTE_W-1:0] byte_for(input logic [BYTEIDX_W-1:0] idx,
                                                 input logic [ADDR_W-1:0] dev,
                                                 input logic rd,
                                                 input logic [BYTE_W-1:0] rg,
                                                 input logic [BYTE_W-1:0] dt);
    logic [BYTE_W-1:0] b;
    if (idx == IDX_ADDR)     b = {dev, 1'b0};
    else if (idx == IDX_REG) b = rg;
    else if (rd)             b = {dev, 1'b1};
    else                     b = dt;
    return b;
  endfunction

  // Latch a new request when idle
  assign start = (phase_r == PH_IDLE) &&
                 ((item.req_type == REQ_WRITE) || (item.req_type == REQ_READ));

  always_comb begin
    if (start) begin
      ph_e      = PH_START;
      reg_e     = item.reg_addr;
      data_e    = item.write_data;
      is_read_e = (item.req_type == REQ_READ);
      nack_e    = 1'b0;
      idx_e     = '0;
      bit_e     = '0;
      shift_e   = '0;
      tick_e    = '0;
    end else begin
      ph_e      = phase_r;
      reg_e     = reg_r;
      data_e    = data_r;
      is_read_e = is_read_r;
      nack_e    = nack_r;
      idx_e     = byte_idx_r;
      bit_e     = bit_cnt_r;
      shift_e   = shift_r;
      tick_e    = tick_r;
    end
  end

  // End of the current phase
  assign half_eff = (cfg.half_ticks == '0) ? HALF_W'(1) : cfg.half_ticks;
  assign last     = ((HALF_W+1)'(tick_e) + (HALF_W+1)'(1)) >= (HALF_W+1)'(half_eff);
  assign idx_inc  = idx_e + BYTEIDX_W'(1);
  assign bit_inc  = bit_e + BITCNT_W'(1);
  assign rd_shift = {shift_e[BYTE_W-2:0], item.sda_in};

  // Next phase
  always_comb begin
    phase_nxt = ph_e;
    if (ph_e != PH_IDLE && last) begin
      unique case (ph_e)
        PH_START:     phase_nxt = PH_BIT_LOW;
        PH_BIT_LOW:   phase_nxt = PH_BIT_HIGH;
        PH_BIT_HIGH:  phase_nxt = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
        PH_ACK_LOW:   phase_nxt = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          if (!is_read_e)
            phase_nxt = (idx_inc >= IDX_LAST) ? PH_STOP_LOW : PH_BIT_LOW;
          else if (idx_inc == IDX_RESTART)
            phase_nxt = PH_RS_LOW;
          else if (idx_inc >= IDX_LAST)
            phase_nxt = PH_RD_LOW;
          else
            phase_nxt = PH_BIT_LOW;
        end
        PH_RS_LOW:    phase_nxt = PH_RS_HIGH;
        PH_RS_HIGH:   phase_nxt = PH_START;
        PH_RD_LOW:    phase_nxt = PH_RD_HIGH;
        PH_RD_HIGH:   phase_nxt = (bit_inc >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_RD_LOW;
        PH_NACK_LOW:  phase_nxt = PH_NACK_HIGH;
        PH_NACK_HIGH: phase_nxt = PH_STOP_LOW;
        PH_STOP_LOW:  phase_nxt = PH_STOP_HIGH;
        PH_STOP_HIGH: phase_nxt = PH_STOP_REL;
        default:      phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Shift, counters and flags
  always_comb begin
    bit_cnt_nxt   = bit_e;
    byte_idx_nxt  = idx_e;
    shift_nxt     = shift_e;
    tick_nxt      = tick_e;
    is_read_nxt   = is_read_e;
    reg_nxt       = reg_e;
    data_nxt      = data_e;
    nack_nxt      = nack_e;
    last_read_nxt = last_read_r;
    if (ph_e != PH_IDLE) begin
      tick_nxt = last ? '0 : tick_e + HALF_W'(1);
      if (last) begin
        case (ph_e)
          PH_START: begin
            shift_nxt   = byte_for(idx_e, cfg.dev_addr, is_read_e, reg_e, data_e);
            bit_cnt_nxt = '0;
          end
          PH_BIT_HIGH: begin
            shift_nxt   = {shift_e[BYTE_W-2:0], 1'b0};
            bit_cnt_nxt = bit_inc;
          end
          PH_ACK_HIGH: begin
            nack_nxt     = nack_e | item.sda_in;
            byte_idx_nxt = idx_inc;
            if (is_read_e && idx_inc >= IDX_LAST) begin
              shift_nxt   = '0;
              bit_cnt_nxt = '0;
            end else if ((!is_read_e && idx_inc < IDX_LAST) ||
                         (is_read_e && idx_inc < IDX_RESTART)) begin
              shift_nxt   = byte_for(idx_inc, cfg.dev_addr, is_read_e, reg_e, data_e);
              bit_cnt_nxt = '0;
            end
          end
          PH_RD_HIGH: begin
            shift_nxt   = rd_shift;
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) last_read_nxt = rd_shift;
          end
          default: ;
        endcase
      end
    end
  end

  // Bus levels and status for this tick
  always_comb begin
    busy = (ph_e != PH_IDLE);
    done = 1'b0;
    unique case (ph_e)
      PH_IDLE:      begin scl = 1'b1; pull = 1'b0; end
      PH_START:     begin scl = 1'b1; pull = 1'b1; end
      PH_BIT_LOW:   begin scl = 1'b0; pull = ~shift_e[BYTE_W-1]; end
      PH_BIT_HIGH:  begin scl = 1'b1; pull = ~shift_e[BYTE_W-1]; end
      PH_ACK_LOW, PH_RS_LOW, PH_RD_LOW, PH_NACK_LOW: begin
        scl = 1'b0; pull = 1'b0;
      end
      PH_STOP_LOW:  begin scl = 1'b0; pull = 1'b1; end
      PH_STOP_HIGH: begin scl = 1'b1; pull = 1'b1; end
      default:      begin scl = 1'b1; pull = 1'b0; end
    endcase
    if (ph_e == PH_STOP_REL && last) begin
      done = 1'b1;
      busy = 1'b0;
    end
  end

  assign res.scl_level    = scl;
  assign res.sda_pull_low = pull;
  assign res.busy_res     = busy;
  assign res.done_res     = done;
  assign res.read_byte    = last_read_nxt;
  assign res.nack_seen    = nack_nxt;

  // Advance the bus state once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      byte_idx_r  <= '0;
      shift_r     <= '0;
      tick_r      <= '0;
      is_read_r   <= 1'b0;
      reg_r       <= '0;
      data_r      <= '0;
      last_read_r <= '0;
      nack_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_idx_r  <= byte_idx_nxt;
      shift_r     <= shift_nxt;
      tick_r      <= tick_nxt;
      is_read_r   <= is_read_nxt;
      reg_r       <= reg_nxt;
      data_r      <= data_nxt;
      last_read_r <= last_read_nxt;
      nack_r      <= nack_nxt;
    end
  end

endmodule

// File: hw/rtl/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// i2c_register_access_master: tick-driven I2C register read/write master
// A word passes from the input register to the result register; one word per cycle while out_ch is not stalled.
// Rate set by the single bus-state update per tick in i2cm_engine.
// Synchronous active-low reset: idle bus, registers at defaults.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  i2cm_cfg_if.sink    cfg_ch
);
  import i2cm_pkg::*;

  item_t in_r, in_nxt;
  logic  in_vld_r, in_vld_nxt;
  res_t  out_r, out_nxt, res;
  logic  out_vld_r, out_vld_nxt;
  logic  step, in_acc;
  cfg_t  cfg;

  i2cm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  i2cm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Move a word from the input register into the result register
  assign step         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    in_nxt.req_type   = in_ch.req_type;
    in_nxt.reg_addr   = in_ch.reg_addr;
    in_nxt.write_data = in_ch.write_data;
    in_nxt.sda_in     = in_ch.sda_in;
    in_vld_nxt        = in_acc ? 1'b1 : (step ? 1'b0 : in_vld_r);
    out_nxt           = res;
    out_vld_nxt       = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (in_acc) in_r <= in_nxt;
    if (step)   out_r <= out_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.scl_level    = out_r.scl_level;
  assign out_ch.sda_pull_low = out_r.sda_pull_low;
  assign out_ch.busy_res     = out_r.busy_res;
  assign out_ch.done_res     = out_r.done_res;
  assign out_ch.read_byte    = out_r.read_byte;
  assign out_ch.nack_seen    = out_r.nack_seen;

endmodule

// File: hw/rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the I2C master.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic scl,
  input logic pull,
  input logic busy,
  input logic done
);

  // Stalled word stays offered
  `I2CM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  // Stop completion ends the transaction
  `I2CM_ASSERT_IMP(a_done_not_busy, out_valid && done, !busy, "done while still busy")

  // Stop completion leaves the bus released
  `I2CM_ASSERT_IMP(a_done_released, out_valid && done, scl && !pull, "bus not released at done")

  // Idle bus keeps SCL high and SDA released
  `I2CM_ASSERT_IMP(a_idle_bus, out_valid && !busy && !done, scl && !pull, "bus driven while idle")

endmodule

bind i2c_register_access_master i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .scl       (out_ch.scl_level),
  .pull      (out_ch.sda_pull_low),
  .busy      (out_ch.busy_res),
  .done      (out_ch.done_res)
);
